// File: design/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants for the postfix evaluator
// Stack sizing, token codes, flag positions and the handshake structs
// between the sequencer, the operand stack and the arithmetic unit.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int DEPTH     = 128;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int FUNC_W    = 3;
    localparam int LEFT_W    = 8;
    localparam int DVD_W     = DATA_W + FRAC_W;
    localparam int ITER_W    = $clog2(DVD_W);
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SUB    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_MUL    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DIV    = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_FINISH = 3'd5;

    localparam int FLAG_UNDER = 0;
    localparam int FLAG_OVER  = 1;
    localparam int FLAG_DIV0  = 2;
    localparam int FLAG_SAT   = 3;
    localparam int FLAG_W     = 4;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [FUNC_W-1:0]        func_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stk_cmd_t;

    typedef struct packed {
        cnt_t count;
        logic empty;
        logic full;
    } stk_stat_t;

    typedef struct packed {
        logic  start;
        func_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic sat;
        logic div0;
    } alu_rsp_t;

    function automatic logic [LEFT_W-1:0] sat_left(input cnt_t c);
        logic [LEFT_W-1:0] r;
        if (32'(c) > 32'd255) begin
            r = '1;
        end else begin
            r = LEFT_W'(c);
        end
        return r;
    endfunction

endpackage

// File: design/rpn_stack.sv
// ----------------------------------------------------------------------------
// rpn_stack: operand stack
// Memory with a write port, a read port and a fill count; push writes at the
// count, pop reads the top entry into a registered read-data output.
// ----------------------------------------------------------------------------
module rpn_stack (
    input  logic              aclk,
    input  logic              aresetn,
    input  rpn_pkg::stk_cmd_t cmd,
    input  rpn_pkg::data_t    wr_data,
    output rpn_pkg::data_t    rd_data,
    output rpn_pkg::stk_stat_t stat
);

    rpn_pkg::data_t mem [rpn_pkg::DEPTH];
    rpn_pkg::data_t rd_data_reg;
    rpn_pkg::cnt_t  count_reg, count_next;
    rpn_pkg::cnt_t  pop_idx;
    logic           empty, full;

    assign empty   = (count_reg == '0);
    assign full    = (32'(count_reg) >= rpn_pkg::DEPTH);
    assign pop_idx = count_reg - rpn_pkg::CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.push && !full) begin
            mem[count_reg[rpn_pkg::ADDR_W-1:0]] <= wr_data;
        end
        if (cmd.pop && !empty) begin
            rd_data_reg <= mem[pop_idx[rpn_pkg::ADDR_W-1:0]];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.clear) begin
            count_next = '0;
        end else if (cmd.push && !full) begin
            count_next = count_reg + rpn_pkg::CNT_W'(1);
        end else if (cmd.pop && !empty) begin
            count_next = pop_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign rd_data    = rd_data_reg;
    assign stat.count = count_reg;
    assign stat.empty = empty;
    assign stat.full  = full;

endmodule

// File: design/rpn_alu.sv
// ----------------------------------------------------------------------------
// rpn_alu: iterative Q16.16 arithmetic unit
// One shared 34-bit adder serves add and subtract in a single pass,
// shift-add multiply and restoring divide one bit per cycle.
// ----------------------------------------------------------------------------
module rpn_alu (
    input  logic              aclk,
    input  logic              aresetn,
    input  rpn_pkg::alu_req_t req,
    input  rpn_pkg::data_t    a,
    input  rpn_pkg::data_t    b,
    output rpn_pkg::data_t    result,
    output rpn_pkg::alu_rsp_t rsp
);

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL  = 3'd1;
    localparam logic [2:0] A_DIV  = 3'd2;
    localparam logic [2:0] A_FIN  = 3'd3;
    localparam logic [2:0] A_DONE = 3'd4;

    localparam int DW = rpn_pkg::DATA_W;
    localparam int VW = rpn_pkg::DVD_W;

    logic [2:0]                state_reg, state_next;
    rpn_pkg::func_t            op_reg, op_next;
    logic [rpn_pkg::ITER_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]             hi_reg, hi_next;
    logic [VW-1:0]             lo_reg, lo_next;
    logic [DW-1:0]             mc_reg, mc_next;
    logic                      neg_reg, neg_next;
    rpn_pkg::data_t            res_reg, res_next;
    logic                      sat_reg, sat_next;
    logic                      dz_reg, dz_next;

    logic [DW+1:0]             add_x, add_y, add_s;
    logic                      add_c;
    logic [DW-1:0]             a_mag, b_mag;
    logic                      last_iter;
    logic signed [2*DW-1:0]    prod_s, round_s, q_s;
    logic [VW-1:0]             qm;

    assign a_mag = a[DW-1] ? (~a + 1'b1) : a;
    assign b_mag = b[DW-1] ? (~b + 1'b1) : b;
    assign add_s = add_x + add_y + (DW+2)'(add_c);

    // shared adder operand select
    always_comb begin
        add_x = '0;
        add_y = '0;
        add_c = 1'b0;
        case (state_reg)
            A_IDLE: begin
                add_x = {{2{a[DW-1]}}, a};
                if (req.op == rpn_pkg::FUNC_SUB) begin
                    add_y = ~{{2{b[DW-1]}}, b};
                    add_c = 1'b1;
                end else begin
                    add_y = {{2{b[DW-1]}}, b};
                end
            end
            A_MUL: begin
                add_x = {2'b00, hi_reg};
                add_y = lo_reg[0] ? {2'b00, mc_reg} : '0;
            end
            A_DIV: begin
                add_x = {1'b0, hi_reg, lo_reg[VW-1]};
                add_y = ~{2'b00, mc_reg};
                add_c = 1'b1;
            end
            default: begin
                add_x = '0;
            end
        endcase
    end

    assign prod_s  = neg_reg ? -$signed({hi_reg, lo_reg[DW-1:0]})
                             : $signed({hi_reg, lo_reg[DW-1:0]});
    assign round_s = prod_s + 64'sd32768;
    assign q_s     = round_s >>> rpn_pkg::FRAC_W;
    assign qm      = lo_reg;

    assign last_iter = (op_reg == rpn_pkg::FUNC_MUL)
                     ? (32'(cnt_reg) == DW - 1) : (32'(cnt_reg) == VW - 1);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        mc_next    = mc_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        sat_next   = sat_reg;
        dz_next    = dz_reg;
        case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    op_next  = req.op;
                    cnt_next = '0;
                    sat_next = 1'b0;
                    dz_next  = 1'b0;
                    neg_next = a[DW-1] ^ b[DW-1];
                    hi_next  = '0;
                    case (req.op)
                        rpn_pkg::FUNC_MUL: begin
                            mc_next    = a_mag;
                            lo_next    = VW'(b_mag);
                            state_next = A_MUL;
                        end
                        rpn_pkg::FUNC_DIV: begin
                            if (b == '0) begin
                                dz_next    = 1'b1;
                                res_next   = a[DW-1] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
                                state_next = A_DONE;
                            end else begin
                                mc_next    = b_mag;
                                lo_next    = {a_mag, {rpn_pkg::FRAC_W{1'b0}}};
                                state_next = A_DIV;
                            end
                        end
                        default: begin
                            if (add_s[DW] != add_s[DW-1]) begin
                                sat_next = 1'b1;
                                res_next = add_s[DW] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
                            end else begin
                                res_next = add_s[DW-1:0];
                            end
                            state_next = A_DONE;
                        end
                    endcase
                end
            end
            A_MUL: begin
                hi_next  = add_s[DW:1];
                lo_next  = {lo_reg[VW-1:DW], add_s[0], lo_reg[DW-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (last_iter) begin
                    state_next = A_FIN;
                end
            end
            A_DIV: begin
                if (!add_s[DW+1]) begin
                    hi_next = add_s[DW-1:0];
                end else begin
                    hi_next = add_x[DW-1:0];
                end
                lo_next  = {lo_reg[VW-2:0], ~add_s[DW+1]};
                cnt_next = cnt_reg + 1'b1;
                if (last_iter) begin
                    state_next = A_FIN;
                end
            end
            A_FIN: begin
                if (op_reg == rpn_pkg::FUNC_MUL) begin
                    if (q_s > 64'sd2147483647) begin
                        sat_next = 1'b1;
                        res_next = rpn_pkg::Q_MAX;
                    end else if (q_s < -64'sd2147483648) begin
                        sat_next = 1'b1;
                        res_next = rpn_pkg::Q_MIN;
                    end else begin
                        res_next = q_s[DW-1:0];
                    end
                end else if (neg_reg) begin
                    if (qm > VW'(48'h0000_8000_0000)) begin
                        sat_next = 1'b1;
                        res_next = rpn_pkg::Q_MIN;
                    end else begin
                        res_next = '0 - qm[DW-1:0];
                    end
                end else begin
                    if (qm > VW'(48'h0000_7FFF_FFFF)) begin
                        sat_next = 1'b1;
                        res_next = rpn_pkg::Q_MAX;
                    end else begin
                        res_next = qm[DW-1:0];
                    end
                end
                state_next = A_DONE;
            end
            A_DONE: begin
                state_next = A_IDLE;
            end
            default: begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
        end else begin
            state_reg <= state_next;
        end
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        mc_reg  <= mc_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
        sat_reg <= sat_next;
        dz_reg  <= dz_next;
    end

    assign result   = res_reg;
    assign rsp.done = (state_reg == A_DONE);
    assign rsp.sat  = sat_reg;
    assign rsp.div0 = dz_reg;

endmodule

// File: design/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator: postfix (RPN) evaluator on a Q16.16 stack
// Sequencer over the operand stack and the shared arithmetic unit.
// ----------------------------------------------------------------------------
// A push beat is taken while idle; add and subtract pass once through the
// shared adder; multiply and divide run the one-bit-per-cycle shift-add
// and restoring-divide loops of the shared arithmetic unit; finish waits
// for the result register to be free. s_axis_tready is low while a
// beat is in work. Only a finish beat produces a result beat; the result
// register lets the next expression start while the answer waits. Error flags
// are sticky until finish, which reports them and empties the stack.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // func[2:0], operand_value[34:3], zero pad[39:35]
    input  logic [rpn_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // answer[31:0], underflow[32], overflow[33], div_by_zero[34],
    // saturated[35], leftover[43:36], zero pad[47:44]
    output logic [rpn_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POPA = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]                     state_reg, state_next;
    rpn_pkg::func_t                 op_reg, op_next;
    rpn_pkg::data_t                 b_reg, b_next;
    logic                           hit_reg, hit_next;
    logic [rpn_pkg::FLAG_W-1:0]     flags_reg, flags_next;
    logic                           m_valid_reg, m_valid_next;
    logic [rpn_pkg::M_TDATA_W-1:0]  m_data_reg, m_data_next;

    rpn_pkg::func_t                 s_func;
    rpn_pkg::data_t                 s_operand;
    logic                           s_beat;
    logic                           out_free;

    rpn_pkg::stk_cmd_t              stk_cmd;
    rpn_pkg::stk_stat_t             stk_stat;
    rpn_pkg::data_t                 stk_wr_data;
    rpn_pkg::data_t                 stk_rd_data;
    rpn_pkg::data_t                 pop_val;

    rpn_pkg::alu_req_t              alu_req;
    rpn_pkg::alu_rsp_t              alu_rsp;
    rpn_pkg::data_t                 alu_result;

    assign s_func    = s_axis_tdata[rpn_pkg::FUNC_W-1:0];
    assign s_operand = s_axis_tdata[rpn_pkg::FUNC_W +: rpn_pkg::DATA_W];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_beat    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign pop_val   = hit_reg ? stk_rd_data : '0;

    rpn_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (stk_cmd),
        .wr_data (stk_wr_data),
        .rd_data (stk_rd_data),
        .stat    (stk_stat)
    );

    rpn_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (pop_val),
        .b       (b_reg),
        .result  (alu_result),
        .rsp     (alu_rsp)
    );

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        b_next        = b_reg;
        hit_next      = hit_reg;
        flags_next    = flags_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        stk_cmd       = '0;
        stk_wr_data   = s_operand;
        alu_req.start = 1'b0;
        alu_req.op    = op_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_beat) begin
                    op_next = s_func;
                    if (s_func == rpn_pkg::FUNC_PUSH) begin
                        stk_cmd.push = 1'b1;
                        if (stk_stat.full) begin
                            flags_next[rpn_pkg::FLAG_OVER] = 1'b1;
                        end
                    end else if (s_func inside {rpn_pkg::FUNC_ADD, rpn_pkg::FUNC_SUB,
                                                rpn_pkg::FUNC_MUL, rpn_pkg::FUNC_DIV,
                                                rpn_pkg::FUNC_FINISH}) begin
                        stk_cmd.pop = 1'b1;
                        hit_next    = !stk_stat.empty;
                        if (stk_stat.empty) begin
                            flags_next[rpn_pkg::FLAG_UNDER] = 1'b1;
                        end
                        state_next = (s_func == rpn_pkg::FUNC_FINISH) ? S_FIN : S_POPA;
                    end
                end
            end
            S_POPA: begin
                b_next      = pop_val;
                stk_cmd.pop = 1'b1;
                hit_next    = !stk_stat.empty;
                if (stk_stat.empty) begin
                    flags_next[rpn_pkg::FLAG_UNDER] = 1'b1;
                end
                state_next = S_EXEC;
            end
            S_EXEC: begin
                alu_req.start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT: begin
                if (alu_rsp.done) begin
                    stk_cmd.push = 1'b1;
                    stk_wr_data  = alu_result;
                    if (stk_stat.full) begin
                        flags_next[rpn_pkg::FLAG_OVER] = 1'b1;
                    end
                    if (alu_rsp.sat) begin
                        flags_next[rpn_pkg::FLAG_SAT] = 1'b1;
                    end
                    if (alu_rsp.div0) begin
                        flags_next[rpn_pkg::FLAG_DIV0] = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_FIN: begin
                // hold until the result register is free
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = {4'b0000,
                                     rpn_pkg::sat_left(stk_stat.count),
                                     flags_reg[rpn_pkg::FLAG_SAT],
                                     flags_reg[rpn_pkg::FLAG_DIV0],
                                     flags_reg[rpn_pkg::FLAG_OVER],
                                     flags_reg[rpn_pkg::FLAG_UNDER],
                                     pop_val};
                    stk_cmd.clear = 1'b1;
                    flags_next    = '0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            flags_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            flags_reg   <= flags_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg     <= op_next;
        b_reg      <= b_next;
        hit_reg    <= hit_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// File: tb/postfix_expression_evaluator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_tb: self-checking bench for the RPN evaluator
// Drives postfix token beats, tracks the operand stack and sticky flags in a
// local Q16.16 model, and compares every answer beat field by field. Covers
// saturation, rounding, zero divisors, missing operands, a full stack, unused
// codes, random well-formed and broken expressions, and back-pressure.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_tb;

    localparam int CYCLE_LIMIT = 500_000;
    localparam int PAD_W       = rpn_pkg::S_TDATA_W - rpn_pkg::FUNC_W - rpn_pkg::DATA_W;

    typedef struct {
        rpn_pkg::data_t             answer;
        logic                       underflow;
        logic                       overflow;
        logic                       div_by_zero;
        logic                       saturated;
        logic [rpn_pkg::LEFT_W-1:0] leftover;
    } rpn_answer_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [rpn_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [rpn_pkg::M_TDATA_W-1:0] m_axis_tdata;

    // token-level model of the operand stack
    rpn_pkg::data_t stk_model [rpn_pkg::DEPTH];
    int    stk_depth = 0;
    logic  under_f = 1'b0;
    logic  over_f = 1'b0;
    logic  div0_f = 1'b0;
    logic  sat_f = 1'b0;
    rpn_answer_t answers_pending [$];

    int cycle_cnt = 0;
    int hold_until = 0;
    int sink_stall_left = 0;
    int sink_stall_pct = 20;
    int src_gap_pct = 20;
    int tokens_sent = 0;
    int answers_checked = 0;
    int fail_count = 0;

    rpn_pkg::func_t arith_ops [4] = '{rpn_pkg::FUNC_ADD, rpn_pkg::FUNC_SUB,
                                      rpn_pkg::FUNC_MUL, rpn_pkg::FUNC_DIV};

    postfix_expression_evaluator i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d answers outstanding",
                 cycle_cnt, answers_pending.size());
        $display("Test completed with failures");
        $finish;
    end

    function automatic int stall_len();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    // result side: random stalls plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn || cycle_cnt < hold_until) begin
            m_axis_tready <= 1'b0;
        end else if (sink_stall_left > 0) begin
            sink_stall_left <= sink_stall_left - 1;
            m_axis_tready   <= 1'b0;
        end else if ($urandom_range(0, 99) < sink_stall_pct) begin
            sink_stall_left <= stall_len();
            m_axis_tready   <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic rpn_pkg::data_t clamp_q(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            sat_f = 1'b1;
            return rpn_pkg::Q_MAX;
        end
        if (v < -64'sd2147483648) begin
            sat_f = 1'b1;
            return rpn_pkg::Q_MIN;
        end
        return v[rpn_pkg::DATA_W-1:0];
    endfunction

    function automatic void push_operand(input rpn_pkg::data_t v);
        if (stk_depth < rpn_pkg::DEPTH) begin
            stk_model[stk_depth] = v;
            stk_depth++;
        end else begin
            over_f = 1'b1;
        end
    endfunction

    function automatic logic signed [63:0] pop_operand();
        if (stk_depth == 0) begin
            under_f = 1'b1;
            return 64'sd0;
        end
        stk_depth--;
        return stk_model[stk_depth];
    endfunction

    function automatic void evaluate_token(input rpn_pkg::func_t f, input rpn_pkg::data_t v);
        logic signed [63:0] lhs, rhs, top;
        rpn_pkg::data_t     res;
        rpn_answer_t        ans;
        case (f)
            rpn_pkg::FUNC_PUSH: begin
                push_operand(v);
            end
            rpn_pkg::FUNC_ADD, rpn_pkg::FUNC_SUB, rpn_pkg::FUNC_MUL, rpn_pkg::FUNC_DIV: begin
                rhs = pop_operand();
                lhs = pop_operand();
                if (f == rpn_pkg::FUNC_ADD) begin
                    res = clamp_q(lhs + rhs);
                end else if (f == rpn_pkg::FUNC_SUB) begin
                    res = clamp_q(lhs - rhs);
                end else if (f == rpn_pkg::FUNC_MUL) begin
                    res = clamp_q((lhs * rhs + 64'sd32768) >>> rpn_pkg::FRAC_W);
                end else if (rhs == 64'sd0) begin
                    div0_f = 1'b1;
                    res    = (lhs < 64'sd0) ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
                end else begin
                    res = clamp_q((lhs <<< rpn_pkg::FRAC_W) / rhs);
                end
                push_operand(res);
            end
            rpn_pkg::FUNC_FINISH: begin
                top             = pop_operand();
                ans.answer      = top[rpn_pkg::DATA_W-1:0];
                ans.underflow   = under_f;
                ans.overflow    = over_f;
                ans.div_by_zero = div0_f;
                ans.saturated   = sat_f;
                ans.leftover    = (stk_depth > 255) ? 8'd255
                                                    : rpn_pkg::LEFT_W'(stk_depth);
                answers_pending.push_back(ans);
                stk_depth = 0;
                under_f   = 1'b0;
                over_f    = 1'b0;
                div0_f    = 1'b0;
                sat_f     = 1'b0;
            end
            default: begin
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        if (fail_count <= 50) begin
            $display("[%0t] %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
        end
    endtask

    always @(posedge aclk) begin : check_answer
        rpn_answer_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (answers_pending.size() == 0) begin
                report_mismatch("answer beat with none pending", m_axis_tdata[31:0], '0);
            end else begin
                want = answers_pending.pop_front();
                answers_checked++;
                if (m_axis_tdata[31:0] !== want.answer) begin
                    report_mismatch("answer", m_axis_tdata[31:0], want.answer);
                end
                if (m_axis_tdata[32] !== want.underflow) begin
                    report_mismatch("underflow", 32'(m_axis_tdata[32]),
                                    32'(want.underflow));
                end
                if (m_axis_tdata[33] !== want.overflow) begin
                    report_mismatch("overflow", 32'(m_axis_tdata[33]),
                                    32'(want.overflow));
                end
                if (m_axis_tdata[34] !== want.div_by_zero) begin
                    report_mismatch("div_by_zero", 32'(m_axis_tdata[34]),
                                    32'(want.div_by_zero));
                end
                if (m_axis_tdata[35] !== want.saturated) begin
                    report_mismatch("saturated", 32'(m_axis_tdata[35]),
                                    32'(want.saturated));
                end
                if (m_axis_tdata[43:36] !== want.leftover) begin
                    report_mismatch("leftover", 32'(m_axis_tdata[43:36]),
                                    32'(want.leftover));
                end
            end
        end
    end

    task automatic send_token(input rpn_pkg::func_t f, input rpn_pkg::data_t v);
        int gap;
        s_axis_tdata  <= {{PAD_W{1'b0}}, v, f};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        evaluate_token(f, v);
        tokens_sent++;
        gap = ($urandom_range(0, 99) < src_gap_pct) ? stall_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (answers_pending.size() != 0);
    endtask

    function automatic rpn_pkg::data_t rand_operand();
        rpn_pkg::data_t v;
        int             pick;
        pick = $urandom_range(0, 99);
        v    = $urandom;
        if (pick < 10) begin
            case ($urandom_range(0, 4))
                0:       v = rpn_pkg::Q_MAX;
                1:       v = rpn_pkg::Q_MIN;
                2:       v = '0;
                3:       v = 32'sh0001_0000;
                default: v = -32'sh0001_0000;
            endcase
        end else if (pick < 45) begin
            v = v >>> 12;
        end else if (pick < 75) begin
            v = v >>> 6;
        end
        return v;
    endfunction

    task automatic test_unused_codes();
        send_token(rpn_pkg::FUNC_PUSH, 32'sh0005_4000);
        send_token(rpn_pkg::func_t'(6), 32'shFFFF_FFFF);
        send_token(rpn_pkg::func_t'(7), 32'sh0000_0000);
        send_token(rpn_pkg::FUNC_FINISH, 32'sh0000_0000);
    endtask

    task automatic test_saturation();
        send_token(rpn_pkg::FUNC_PUSH, rpn_pkg::Q_MAX);
        send_token(rpn_pkg::FUNC_PUSH, rpn_pkg::Q_MAX);
        send_token(rpn_pkg::FUNC_ADD, 32'sh0);
        send_token(rpn_pkg::FUNC_PUSH, rpn_pkg::Q_MIN);
        send_token(rpn_pkg::FUNC_MUL, 32'sh0);
        send_token(rpn_pkg::FUNC_FINISH, 32'sh0);
    endtask

    task automatic test_rounding_and_divide();
        send_token(rpn_pkg::FUNC_PUSH, 32'sh0001_8000);
        send_token(rpn_pkg::FUNC_PUSH, -32'sh0002_8000);
        send_token(rpn_pkg::FUNC_MUL, 32'sh0);
        send_token(rpn_pkg::FUNC_PUSH, 32'sh0000_0001);
        send_token(rpn_pkg::FUNC_PUSH, 32'sh0000_8000);
        send_token(rpn_pkg::FUNC_MUL, 32'sh0);
        send_token(rpn_pkg::FUNC_PUSH, rpn_pkg::Q_MIN);
        send_token(rpn_pkg::FUNC_PUSH, 32'sh0);
        send_token(rpn_pkg::FUNC_DIV, 32'sh0);
        send_token(rpn_pkg::FUNC_FINISH, 32'sh0);
    endtask

    task automatic test_missing_operands();
        send_token(rpn_pkg::FUNC_FINISH, 32'sh0);
        send_token(rpn_pkg::FUNC_PUSH, 32'sh0003_0000);
        send_token(rpn_pkg::FUNC_SUB, 32'sh0);
        send_token(rpn_pkg::FUNC_FINISH, 32'sh0);
        send_token(rpn_pkg::FUNC_DIV, 32'sh0);
        send_token(rpn_pkg::FUNC_FINISH, 32'sh0);
    endtask

    task automatic test_stack_full();
        repeat (rpn_pkg::DEPTH + 2) send_token(rpn_pkg::FUNC_PUSH, rand_operand());
        send_token(rpn_pkg::FUNC_ADD, 32'sh0);
        send_token(rpn_pkg::FUNC_FINISH, 32'sh0);
    endtask

    // hold the result side while the sender streams without gaps
    task automatic test_backpressure();
        int saved_gap;
        saved_gap   = src_gap_pct;
        src_gap_pct = 0;
        hold_until  = cycle_cnt + 400;
        repeat (6) begin
            send_token(rpn_pkg::FUNC_PUSH, rand_operand());
            send_token(rpn_pkg::FUNC_PUSH, rand_operand());
            send_token(arith_ops[$urandom_range(0, 3)], 32'sh0);
            send_token(rpn_pkg::FUNC_FINISH, 32'sh0);
        end
        src_gap_pct = saved_gap;
        wait_drain();
    endtask

    task automatic send_wellformed();
        int keep, to_push, depth;
        keep    = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 4) : 1;
        to_push = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
        if (to_push < keep) begin
            to_push = keep;
        end
        depth = 0;
        while (to_push > 0 || depth > keep) begin
            if (depth >= 2 && (to_push == 0 || $urandom_range(0, 2) == 0)) begin
                send_token(arith_ops[$urandom_range(0, 3)], rpn_pkg::data_t'($urandom));
                depth--;
            end else begin
                send_token(rpn_pkg::FUNC_PUSH, rand_operand());
                depth++;
                to_push--;
            end
        end
        send_token(rpn_pkg::FUNC_FINISH, rpn_pkg::data_t'($urandom));
    endtask

    task automatic send_broken();
        repeat ($urandom_range(1, 8)) begin
            send_token(rpn_pkg::func_t'($urandom_range(0, 7)), rand_operand());
        end
        send_token(rpn_pkg::FUNC_FINISH, rpn_pkg::data_t'($urandom));
    endtask

    task automatic test_random_expressions(input int n_tokens);
        int start;
        start = tokens_sent;
        while (tokens_sent - start < n_tokens) begin
            if ($urandom_range(0, 99) < 85) begin
                send_wellformed();
            end else begin
                send_broken();
            end
            if ($urandom_range(0, 19) == 0) begin
                wait_drain();
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unused_codes();
        test_saturation();
        test_rounding_and_divide();
        test_missing_operands();
        test_stack_full();
        wait_drain();
        test_backpressure();

        src_gap_pct    = 40;
        sink_stall_pct = 30;
        test_random_expressions(180);
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        test_random_expressions(100);
        src_gap_pct    = 60;
        sink_stall_pct = 60;
        test_random_expressions(80);

        wait_drain();
        repeat (100) @(posedge aclk);
        if (answers_pending.size() != 0) begin
            report_mismatch("answers never delivered", 32'(answers_pending.size()), 32'd0);
        end
        $display("Sent %0d token beats and checked %0d answer beats.",
                 tokens_sent, answers_checked);
        $display("Run covered saturation, rounding, zero divisors, missing operands,");
        $display("a full stack, unused codes, random expressions and back-pressure.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
